/* src/sliding_polynomial_fit_filter_unit_assert.svh */
// Assertion macros shared by the checker of the polynomial fit filter
`ifndef SLIDING_POLYNOMIAL_FIT_FILTER_UNIT_ASSERT_SVH
`define SLIDING_POLYNOMIAL_FIT_FILTER_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define SGF_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("filter check failed in the same cycle");

// Consequent checked in the cycle after the antecedent
`define SGF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("filter check failed one cycle later");

`endif

/* src/sgf_pkg.sv */
// Types and constants of the sliding polynomial fit filter
package sgf_pkg;

   localparam int VALUE_W    = 32;
   localparam int COEF_W     = 64;
   localparam int HALF_W     = COEF_W / 2;
   localparam int EST_W      = 64;
   localparam int CMD_W      = 2;
   localparam int ORDER_W    = 2;
   localparam int CIDX_W     = 5;
   localparam int WLEN_W     = 6;
   localparam int NUM_ORDERS = 4;
   localparam int FRAC_SHIFT = 24;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 8;

   // Register map
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_LENGTH = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_FIT_ORDER     = CSR_IDX_W'(1);

   typedef enum logic [CMD_W-1:0] {
      CMD_SAMPLE  = 2'd0,
      CMD_REALIGN = 2'd1,
      CMD_LOAD    = 2'd2
   } cmd_type;

   // Sequencer controls for the shared multiply-accumulate unit
   typedef struct packed {
      logic clear;   // zero the accumulator
      logic load;    // capture sample difference and coefficient
      logic mul;     // multiply one coefficient half
      logic hi;      // upper coefficient half
      logic round;   // round accumulator to Q.16
   } mac_ctl_type;

endpackage

/* src/sgf_if.sv */
// Handshake channel interfaces: sample/command input, estimate output, register writes
interface sgf_req_if;
   import sgf_pkg::*;
   logic                        valid;
   logic                        ready;
   logic [CMD_W-1:0]            command;
   logic signed [VALUE_W-1:0]   value;
   logic [ORDER_W-1:0]          coef_order;
   logic [CIDX_W-1:0]           coef_index;
   logic signed [COEF_W-1:0]    coef_value;

   modport source (output valid, command, value, coef_order, coef_index, coef_value,
                   input ready);
   modport sink   (input valid, command, value, coef_order, coef_index, coef_value,
                   output ready);
endinterface

interface sgf_rsp_if;
   import sgf_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [EST_W-1:0]  level_est;
   logic signed [EST_W-1:0]  rate_est;
   logic signed [EST_W-1:0]  accel_est;
   logic signed [EST_W-1:0]  jerk_est;
   logic                     window_full;

   modport source (output valid, level_est, rate_est, accel_est, jerk_est, window_full,
                   input ready);
   modport sink   (input valid, level_est, rate_est, accel_est, jerk_est, window_full,
                   output ready);
endinterface

interface sgf_csr_if;
   import sgf_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* src/sgf_store.sv */
// Sample ring and coefficient table memories with registered read ports
module sgf_store
   import sgf_pkg::*;
#(
   parameter int  MAX_WINDOW = 32,
   localparam int RING_AW    = $clog2(MAX_WINDOW),
   localparam int COEF_DEPTH = NUM_ORDERS * MAX_WINDOW,
   localparam int COEF_AW    = $clog2(COEF_DEPTH)
) (
   input  logic               clock,
   input  logic               ring_we,
   input  logic [RING_AW-1:0] ring_waddr,
   input  logic [VALUE_W-1:0] ring_wdata,
   input  logic               ring_re,
   input  logic [RING_AW-1:0] ring_raddr,
   output logic [VALUE_W-1:0] ring_rdata,
   input  logic               coef_we,
   input  logic [COEF_AW-1:0] coef_waddr,
   input  logic [COEF_W-1:0]  coef_wdata,
   input  logic               coef_re,
   input  logic [COEF_AW-1:0] coef_raddr,
   output logic [COEF_W-1:0]  coef_rdata
);

   logic [VALUE_W-1:0] ring_mem [MAX_WINDOW];
   logic [COEF_W-1:0]  coef_mem [COEF_DEPTH];
   logic [VALUE_W-1:0] ring_rdata_ff;
   logic [COEF_W-1:0]  coef_rdata_ff;

   // Sample ring: one write, one registered read
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[ring_waddr] <= ring_wdata;
      end
      if (ring_re) begin
         ring_rdata_ff <= ring_mem[ring_raddr];
      end
   end

   // Coefficient table, order-major
   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[coef_waddr] <= coef_wdata;
      end
      if (coef_re) begin
         coef_rdata_ff <= coef_mem[coef_raddr];
      end
   end

   assign ring_rdata = ring_rdata_ff;
   assign coef_rdata = coef_rdata_ff;

endmodule

/* src/sgf_mac.sv */
// Shared 33x33 multiplier, wide accumulator, rounding and saturation
module sgf_mac
   import sgf_pkg::*;
#(
   parameter int MAX_WINDOW = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  mac_ctl_type                ctl,
   input  logic signed [VALUE_W-1:0]  sample,
   input  logic [COEF_W-1:0]          coef,
   input  logic signed [VALUE_W-1:0]  newest,
   output logic signed [EST_W-1:0]    sat_est
);

   localparam int DIFF_W = VALUE_W + 1;
   localparam int PROD_W = 2 * DIFF_W;
   // full product is DIFF_W + COEF_W bits, plus growth over the window
   localparam int ACC_W  = DIFF_W + COEF_W + $clog2(MAX_WINDOW) + 1;
   localparam int RND_W  = ACC_W - FRAC_SHIFT;
   localparam int SUM_W  = RND_W + 1;

   logic signed [DIFF_W-1:0] diff_ff, diff_in;
   logic [COEF_W-1:0]        coef_ff;
   logic signed [DIFF_W-1:0] mul_b;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     prod_vld_ff;
   logic                     prod_hi_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in, addend, acc_rnd;
   logic signed [RND_W-1:0]  rnd_ff, rnd_in;
   logic signed [SUM_W-1:0]  sum;
   logic [SUM_W-EST_W:0]     sum_top;

   // Difference of the stored sample to the newest one
   assign diff_in = DIFF_W'(sample) - DIFF_W'(newest);

   // Coefficient half: low half unsigned, high half signed
   assign mul_b = ctl.hi ? DIFF_W'($signed(coef_ff[COEF_W-1:HALF_W]))
                         : $signed({1'b0, coef_ff[HALF_W-1:0]});
   assign prod_in = diff_ff * mul_b;

   // Accumulate the previous cycle's product, high half weighted by 2^32
   assign addend = prod_hi_ff ? (ACC_W'(prod_ff) <<< HALF_W) : ACC_W'(prod_ff);

   always_comb begin
      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + addend;
      end
   end

   // Round half up from Q.40 to Q.16
   assign acc_rnd = acc_ff + (ACC_W'(1) <<< (FRAC_SHIFT - 1));
   assign rnd_in  = RND_W'(acc_rnd >>> FRAC_SHIFT);

   // Add newest sample and clamp to the 64-bit range
   assign sum     = SUM_W'(rnd_ff) + SUM_W'(newest);
   assign sum_top = sum[SUM_W-1:EST_W-1];

   always_comb begin
      if ((&sum_top) || !(|sum_top)) begin
         sat_est = sum[EST_W-1:0];
      end else if (sum[SUM_W-1]) begin
         sat_est = {1'b1, {(EST_W-1){1'b0}}};
      end else begin
         sat_est = {1'b0, {(EST_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= ctl.mul;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         diff_ff <= diff_in;
         coef_ff <= coef;
      end
      if (ctl.mul) begin
         prod_ff    <= prod_in;
         prod_hi_ff <= ctl.hi;
      end
      if (ctl.round) begin
         rnd_ff <= rnd_in;
      end
      acc_ff <= acc_in;
   end

endmodule

/* src/sliding_polynomial_fit_filter_unit.sv */
// Realign, coefficient load and ignored items are taken in ST_IDLE, ready stays high.
// Warm-up sample: result goes through ST_EMIT into the output register, not ready until then.
// Full-window sample: busy while each order up to fit_order is computed, each tap takes two
// passes through the single 33x33 multiplier; one item at a time, not ready meanwhile.
// Reset (synchronous): clears state, configuration, history and the output valid; sample ring and
// coefficient table keep their contents.
module sliding_polynomial_fit_filter_unit
   import sgf_pkg::*;
#(
   parameter int MAX_WINDOW = 32
) (
   input  logic       clock,
   input  logic       reset,
   sgf_req_if.sink    req_chan,
   sgf_rsp_if.source  rsp_chan,
   sgf_csr_if.sink    csr_chan
);

   localparam int RING_AW = $clog2(MAX_WINDOW);
   localparam int FILL_W  = $clog2(MAX_WINDOW + 1);
   localparam int COEF_AW = $clog2(NUM_ORDERS * MAX_WINDOW);

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_FETCH  = 9'b000000010,
      ST_LOAD   = 9'b000000100,
      ST_MUL_LO = 9'b000001000,
      ST_MUL_HI = 9'b000010000,
      ST_DRAIN  = 9'b000100000,
      ST_ROUND  = 9'b001000000,
      ST_SAT    = 9'b010000000,
      ST_EMIT   = 9'b100000000
   } state_type;

   state_type                 state_ff, state_in;
   logic [WLEN_W-1:0]         wlen_ff, wlen_in;
   logic [ORDER_W-1:0]        order_ff, order_in;
   logic [RING_AW-1:0]        wslot_ff, wslot_in;
   logic [FILL_W-1:0]         fill_ff, fill_in;
   logic signed [VALUE_W-1:0] newest_ff, newest_in;
   logic signed [EST_W-1:0]   est_ff [NUM_ORDERS];
   logic signed [EST_W-1:0]   est_in [NUM_ORDERS];
   logic                      full_ff, full_in;
   logic [ORDER_W-1:0]        dsel_ff, dsel_in;
   logic [RING_AW-1:0]        slot_ff, slot_in;
   logic [FILL_W-1:0]         tap_ff, tap_in;
   logic [COEF_AW-1:0]        caddr_ff, caddr_in;
   logic [COEF_AW-1:0]        cbase_ff, cbase_in;
   logic                      last_ff, last_in;
   logic                      rsp_vld_ff, rsp_vld_in;
   logic signed [EST_W-1:0]   rsp_est_ff [NUM_ORDERS];
   logic                      rsp_full_ff;
   logic                      rsp_load;

   logic                      req_fire, csr_fire, cfg_ok, issue;
   cmd_type                   cmd;
   logic [FILL_W-1:0]         wlen_f, ws_inc_f, fill_next, slot_inc_f;
   logic [RING_AW-1:0]        ws_eff, ws_next, slot_wrap;
   logic                      ring_we, coef_we;
   logic [COEF_AW-1:0]        coef_waddr;
   logic [VALUE_W-1:0]        ring_rdata;
   logic [COEF_W-1:0]         coef_rdata;
   logic signed [EST_W-1:0]   sat_est;
   mac_ctl_type               mac_ctl;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign csr_fire = csr_chan.valid && csr_chan.ready;
   assign cmd      = cmd_type'(req_chan.command);

   // Window must hold more samples than the fit order and fit the ring
   assign cfg_ok = (wlen_ff != '0) && (wlen_ff > WLEN_W'(order_ff))
                   && (int'(wlen_ff) <= MAX_WINDOW);
   assign wlen_f = FILL_W'(wlen_ff);

   // Ring write slot with wrap at the window length
   assign ws_eff    = (FILL_W'(wslot_ff) >= wlen_f) ? '0 : wslot_ff;
   assign ws_inc_f  = FILL_W'(ws_eff) + FILL_W'(1);
   assign ws_next   = (ws_inc_f >= wlen_f) ? '0 : RING_AW'(ws_inc_f);
   assign fill_next = (fill_ff < wlen_f) ? fill_ff + FILL_W'(1) : fill_ff;

   // Read pointer walks oldest to newest
   assign slot_inc_f = FILL_W'(slot_ff) + FILL_W'(1);
   assign slot_wrap  = (slot_inc_f == wlen_f) ? '0 : RING_AW'(slot_inc_f);

   // Coefficient load, out-of-range positions dropped
   assign coef_we    = req_fire && (cmd == CMD_LOAD)
                       && (int'(req_chan.coef_index) < MAX_WINDOW);
   assign coef_waddr = COEF_AW'(req_chan.coef_order) * COEF_AW'(MAX_WINDOW)
                       + COEF_AW'(req_chan.coef_index);

   // Sequencer
   always_comb begin
      state_in = state_ff;
      wlen_in  = wlen_ff;
      order_in = order_ff;
      wslot_in = wslot_ff;
      fill_in  = fill_ff;
      newest_in = newest_ff;
      for (int i = 0; i < NUM_ORDERS; i++) begin
         est_in[i] = est_ff[i];
      end
      full_in  = full_ff;
      dsel_in  = dsel_ff;
      slot_in  = slot_ff;
      tap_in   = tap_ff;
      caddr_in = caddr_ff;
      cbase_in = cbase_ff;
      last_in  = last_ff;
      ring_we  = 1'b0;
      issue    = 1'b0;
      rsp_load = 1'b0;
      mac_ctl  = '0;
      rsp_vld_in = rsp_vld_ff && !rsp_chan.ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (cmd)
                  CMD_SAMPLE: begin
                     if (cfg_ok) begin
                        ring_we   = 1'b1;
                        wslot_in  = ws_next;
                        fill_in   = fill_next;
                        newest_in = req_chan.value;
                        est_in[0] = EST_W'(req_chan.value);
                        for (int i = 1; i < NUM_ORDERS; i++) begin
                           est_in[i] = '0;
                        end
                        dsel_in  = '0;
                        slot_in  = ws_next;
                        tap_in   = '0;
                        caddr_in = '0;
                        cbase_in = '0;
                        if (fill_next == wlen_f) begin
                           full_in  = 1'b1;
                           state_in = ST_FETCH;
                        end else begin
                           full_in  = 1'b0;
                           state_in = ST_EMIT;
                        end
                     end
                  end
                  CMD_REALIGN: begin
                     wslot_in = '0;
                     fill_in  = '0;
                  end
                  CMD_LOAD: begin
                     // table write handled by coef_we
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FETCH: begin
            issue         = 1'b1;
            mac_ctl.clear = 1'b1;
            state_in      = ST_LOAD;
         end
         ST_LOAD: begin
            mac_ctl.load = 1'b1;
            state_in     = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            mac_ctl.mul = 1'b1;
            // prefetch the next tap while this one multiplies
            if (tap_ff != wlen_f) begin
               issue   = 1'b1;
               last_in = 1'b0;
            end else begin
               last_in = 1'b1;
            end
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            mac_ctl.mul = 1'b1;
            mac_ctl.hi  = 1'b1;
            if (last_ff) begin
               state_in = ST_DRAIN;
            end else begin
               mac_ctl.load = 1'b1;
               state_in     = ST_MUL_LO;
            end
         end
         ST_DRAIN: begin
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            mac_ctl.round = 1'b1;
            state_in      = ST_SAT;
         end
         ST_SAT: begin
            est_in[dsel_ff] = sat_est;
            if (dsel_ff == order_ff) begin
               state_in = ST_EMIT;
            end else begin
               dsel_in  = dsel_ff + ORDER_W'(1);
               cbase_in = cbase_ff + COEF_AW'(MAX_WINDOW);
               caddr_in = cbase_ff + COEF_AW'(MAX_WINDOW);
               slot_in  = wslot_ff;
               tap_in   = '0;
               state_in = ST_FETCH;
            end
         end
         ST_EMIT: begin
            if (!rsp_vld_ff || rsp_chan.ready) begin
               rsp_load   = 1'b1;
               rsp_vld_in = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Tap read issue advances the pointers
      if (issue) begin
         slot_in  = slot_wrap;
         caddr_in = caddr_ff + COEF_AW'(1);
         tap_in   = tap_ff + FILL_W'(1);
      end

      // Writes to the window length or fit order register clear history
      if (csr_fire) begin
         if (csr_chan.index == REG_WINDOW_LENGTH) begin
            wlen_in  = csr_chan.data[WLEN_W-1:0];
            wslot_in = '0;
            fill_in  = '0;
         end else if (csr_chan.index == REG_FIT_ORDER) begin
            order_in = csr_chan.data[ORDER_W-1:0];
            wslot_in = '0;
            fill_in  = '0;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         wlen_ff    <= '0;
         order_ff   <= '0;
         wslot_ff   <= '0;
         fill_ff    <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         wlen_ff    <= wlen_in;
         order_ff   <= order_in;
         wslot_ff   <= wslot_in;
         fill_ff    <= fill_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Sequencer counters and payload
   always_ff @(posedge clock) begin
      newest_ff <= newest_in;
      full_ff   <= full_in;
      dsel_ff   <= dsel_in;
      slot_ff   <= slot_in;
      tap_ff    <= tap_in;
      caddr_ff  <= caddr_in;
      cbase_ff  <= cbase_in;
      last_ff   <= last_in;
      for (int i = 0; i < NUM_ORDERS; i++) begin
         est_ff[i] <= est_in[i];
      end
      if (rsp_load) begin
         for (int i = 0; i < NUM_ORDERS; i++) begin
            rsp_est_ff[i] <= est_ff[i];
         end
         rsp_full_ff <= full_ff;
      end
   end

   sgf_store #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_store (
      .clock      (clock),
      .ring_we    (ring_we),
      .ring_waddr (ws_eff),
      .ring_wdata (req_chan.value),
      .ring_re    (issue),
      .ring_raddr (slot_ff),
      .ring_rdata (ring_rdata),
      .coef_we    (coef_we),
      .coef_waddr (coef_waddr),
      .coef_wdata (req_chan.coef_value),
      .coef_re    (issue),
      .coef_raddr (caddr_ff),
      .coef_rdata (coef_rdata)
   );

   sgf_mac #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mac_ctl),
      .sample  (ring_rdata),
      .coef    (coef_rdata),
      .newest  (newest_ff),
      .sat_est (sat_est)
   );

   // Ports
   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign csr_chan.ready       = 1'b1;
   assign rsp_chan.valid       = rsp_vld_ff;
   assign rsp_chan.level_est   = rsp_est_ff[0];
   assign rsp_chan.rate_est    = rsp_est_ff[1];
   assign rsp_chan.accel_est   = rsp_est_ff[2];
   assign rsp_chan.jerk_est    = rsp_est_ff[3];
   assign rsp_chan.window_full = rsp_full_ff;

endmodule

/* src/sgf_checker.sv */
// Port-level checks of the polynomial fit filter and their bind to the top level
`include "sliding_polynomial_fit_filter_unit_assert.svh"

module sgf_checker
   import sgf_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic signed [EST_W-1:0] rsp_level,
   input logic signed [EST_W-1:0] rsp_rate,
   input logic signed [EST_W-1:0] rsp_accel,
   input logic signed [EST_W-1:0] rsp_jerk,
   input logic                    rsp_full
);

   // A stalled result stays valid and keeps its level, rate and window_full
   `SGF_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_level) && $stable(rsp_rate) && $stable(rsp_full))

   // Warm-up results carry no derivatives
   `SGF_ASSERT_SAME(a_warmup_zero, rsp_valid && !rsp_full, rsp_rate == 0 && rsp_accel == 0 && rsp_jerk == 0)

   // A new result only follows a busy cycle
   `SGF_ASSERT_SAME(a_rsp_after_busy, $rose(rsp_valid), $past(!req_ready))

   // The block only goes busy on an accepted item
   `SGF_ASSERT_SAME(a_busy_on_accept, $fell(req_ready), $past(req_valid))

endmodule

bind sliding_polynomial_fit_filter_unit sgf_checker u_sgf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_level (rsp_chan.level_est),
   .rsp_rate  (rsp_chan.rate_est),
   .rsp_accel (rsp_chan.accel_est),
   .rsp_jerk  (rsp_chan.jerk_est),
   .rsp_full  (rsp_chan.window_full)
);

/* tb/sliding_polynomial_fit_filter_unit_tb.sv */
// Self-checking testbench for the sliding polynomial fit filter: directed table, coefficient fill, then random phases
`timescale 1ns / 100ps

module sliding_polynomial_fit_filter_unit_tb;
   import sgf_pkg::*;

   localparam int MAX_WIN      = 32;
   localparam int RAND_ITEMS   = 450;
   localparam int CYCLE_LIMIT  = 1_500_000;
   localparam int IDLE_SETTLE  = 6;
   localparam int TAIL_CYCLES  = 400;
   localparam int DRAIN_LIMIT  = 20_000;
   localparam int PRINT_CAP    = 40;
   localparam int NUM_PRESETS  = 12;

   localparam logic [CMD_W-1:0]     CMD_UNUSED       = 2'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_UNUSED = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_LAST_INDEX   = '1;

   localparam logic signed [127:0] ROUND_HALF = 128'sd8388608;
   localparam logic signed [127:0] EST_MAX    = 128'sh7fff_ffff_ffff_ffff;
   localparam logic signed [127:0] EST_MIN    = -EST_MAX - 1;

   typedef struct packed {
      logic signed [EST_W-1:0] level;
      logic signed [EST_W-1:0] rate;
      logic signed [EST_W-1:0] accel;
      logic signed [EST_W-1:0] jerk;
      logic                    full;
   } est_t;

   typedef enum logic [1:0] {ROW_ITEM, ROW_CSR} row_kind_t;
   // How a row's result is known: from the predictor, none at all, or a warm-up echo
   typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_WARM} row_check_t;

   typedef struct packed {
      row_kind_t             kind;
      row_check_t            check;
      logic [CMD_W-1:0]      cmd;
      logic [VALUE_W-1:0]    value;
      logic [ORDER_W-1:0]    corder;
      logic [CIDX_W-1:0]     cidx;
      logic [COEF_W-1:0]     cvalue;
      logic [CSR_IDX_W-1:0]  csr_idx;
      logic [CSR_DATA_W-1:0] csr_data;
   } stim_row_t;

   logic clock;
   logic reset;

   sgf_req_if req_bus ();
   sgf_rsp_if rsp_bus ();
   sgf_csr_if csr_bus ();

   sliding_polynomial_fit_filter_unit #(.MAX_WINDOW(MAX_WIN)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // Predictor state
   logic signed [VALUE_W-1:0] hist_ring [MAX_WIN];
   logic signed [COEF_W-1:0]  coef_bank [NUM_ORDERS][MAX_WIN];
   int                        hist_slot;
   int                        hist_fill;
   int                        cfg_window;
   int                        cfg_order;

   est_t      pending_est [$];
   est_t      want;
   stim_row_t stim_table [$];
   int        errors;
   int        cycles = 0;
   int        rsp_hold = 0;
   bit        steady_tx;
   bit        steady_rx;

   int preset_win [NUM_PRESETS] = '{32, 2, 1, 0, 40, 5, 32, 3, 63, 17, 8, 1};
   int preset_ord [NUM_PRESETS] = '{3, 1, 0, 0, 2, 2, 0, 3, 3, 3, 1, 0};

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] exp_val);
      errors++;
      if (errors <= PRINT_CAP)
         $display("mismatch %0d at cycle %0d: %s got %h exp %h", errors, cycles, what, got,
                  exp_val);
   endtask

   // Mostly short gaps, some longer ones; none at all in steady stretches
   function automatic int pick_gap(bit steady);
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [VALUE_W-1:0] rand_sample();
      logic [31:0] v;
      int          r;
      v = $urandom;
      r = $urandom_range(0, 99);
      if (r < 70) return {{12{v[19]}}, v[19:0]};
      if (r < 90) return v;
      case (r % 4)
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return '0;
         default: return '1;
      endcase
   endfunction

   // Moderate coefficients keep sums in range; wild ones reach full width and extremes
   function automatic logic [COEF_W-1:0] rand_coef(bit wild);
      logic [63:0] c;
      int          r;
      c = {$urandom, $urandom};
      r = $urandom_range(0, 99);
      if (!wild || r < 75) return {{34{c[29]}}, c[29:0]};
      if (r < 90) return c;
      case (r % 4)
         0: return 64'h7fff_ffff_ffff_ffff;
         1: return 64'h8000_0000_0000_0000;
         2: return '0;
         default: return '1;
      endcase
   endfunction

   // Round Q.40 sum to Q.16, add newest sample, clamp to 64-bit signed
   function automatic logic signed [EST_W-1:0] round_saturate(input logic signed [127:0] acc,
                                                              input logic signed [63:0] newest);
      logic signed [127:0] s;
      s = ((acc + ROUND_HALF) >>> FRAC_SHIFT) + newest;
      if (s > EST_MAX) return EST_MAX[63:0];
      if (s < EST_MIN) return EST_MIN[63:0];
      return s[63:0];
   endfunction

   // Expected effect of one accepted item; returns 1 when it yields an estimate
   function automatic bit predict_fit(input logic [CMD_W-1:0] cmd,
                                      input logic signed [VALUE_W-1:0] value,
                                      input logic [ORDER_W-1:0] corder,
                                      input logic [CIDX_W-1:0] cidx,
                                      input logic signed [COEF_W-1:0] cvalue,
                                      output est_t est);
      logic signed [63:0]  newest;
      logic signed [63:0]  outs [NUM_ORDERS];
      logic signed [127:0] acc;
      logic signed [127:0] dw;
      logic signed [127:0] cw;
      logic signed [32:0]  diff;
      int                  p;
      est = '0;
      newest = value;
      case (cmd)
         CMD_REALIGN: begin
            hist_slot = 0;
            hist_fill = 0;
            return 1'b0;
         end
         CMD_LOAD: begin
            coef_bank[corder][cidx] = cvalue;
            return 1'b0;
         end
         CMD_SAMPLE: ;
         default: return 1'b0;
      endcase
      if (cfg_window == 0 || cfg_window <= cfg_order || cfg_window > MAX_WIN) return 1'b0;

      if (hist_slot >= cfg_window) hist_slot = 0;
      hist_ring[hist_slot] = value;
      hist_slot++;
      if (hist_slot >= cfg_window) hist_slot = 0;
      if (hist_fill < cfg_window) hist_fill++;

      est.level = newest;
      if (hist_fill < cfg_window) return 1'b1;

      // Full window: walk from oldest (current write slot) to newest
      for (int d = 0; d < NUM_ORDERS; d++) outs[d] = '0;
      for (int d = 0; d <= cfg_order; d++) begin
         acc = '0;
         p = hist_slot;
         for (int k = 0; k < cfg_window; k++) begin
            diff = $signed({hist_ring[p][31], hist_ring[p]}) - $signed({value[31], value});
            dw = diff;
            cw = coef_bank[d][k];
            acc = acc + dw * cw;
            p++;
            if (p >= cfg_window) p = 0;
         end
         outs[d] = round_saturate(acc, newest);
      end
      est.level = outs[0];
      est.rate  = outs[1];
      est.accel = outs[2];
      est.jerk  = outs[3];
      est.full  = 1'b1;
      return 1'b1;
   endfunction

   function automatic stim_row_t item_row(input logic [CMD_W-1:0] cmd,
                                          input logic [VALUE_W-1:0] value,
                                          input logic [ORDER_W-1:0] corder,
                                          input logic [CIDX_W-1:0] cidx,
                                          input logic [COEF_W-1:0] cvalue,
                                          input row_check_t check);
      stim_row_t r;
      r = '0;
      r.kind = ROW_ITEM;
      r.check = check;
      r.cmd = cmd;
      r.value = value;
      r.corder = corder;
      r.cidx = cidx;
      r.cvalue = cvalue;
      return r;
   endfunction

   function automatic stim_row_t csr_row(input logic [CSR_IDX_W-1:0] idx,
                                         input logic [CSR_DATA_W-1:0] data);
      stim_row_t r;
      r = '0;
      r.kind = ROW_CSR;
      r.check = CHK_NONE;
      r.csr_idx = idx;
      r.csr_data = data;
      return r;
   endfunction

   // Drive one item, wait for acceptance, record its expected estimate
   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value,
                            input logic [ORDER_W-1:0] corder, input logic [CIDX_W-1:0] cidx,
                            input logic [COEF_W-1:0] cvalue, input row_check_t check,
                            output bit counted);
      est_t est;
      bit   has;
      int   gap;
      @(negedge clock);
      req_bus.valid      = 1'b1;
      req_bus.command    = cmd;
      req_bus.value      = value;
      req_bus.coef_order = corder;
      req_bus.coef_index = cidx;
      req_bus.coef_value = cvalue;
      do @(posedge clock); while (!req_bus.ready);
      has = predict_fit(cmd, value, corder, cidx, cvalue, est);
      if (check == CHK_WARM) est = '{{{32{value[31]}}, value}, 64'd0, 64'd0, 64'd0, 1'b0};
      if (check != CHK_NONE && has) pending_est.push_back(est);
      counted = has || cmd == CMD_LOAD || cmd == CMD_REALIGN;
      gap = pick_gap(steady_tx);
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Register write; either known register restarts the history
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data  = data;
      do @(posedge clock); while (!csr_bus.ready);
      if (idx == REG_WINDOW_LENGTH || idx == REG_FIT_ORDER) begin
         if (idx == REG_WINDOW_LENGTH) cfg_window = data[5:0];
         else cfg_order = data[1:0];
         hist_slot = 0;
         hist_fill = 0;
      end
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // Hold off the sender until every pending estimate is back and the block settles
   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pending_est.size() != 0) @(posedge clock);
      repeat (IDLE_SETTLE) @(negedge clock);
   endtask

   // Result receiver with random stalls
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_bus.ready = 1'b0;
         rsp_hold = rsp_hold - 1;
      end else begin
         rsp_bus.ready = 1'b1;
         if ($urandom_range(0, 99) < 25) rsp_hold = pick_gap(steady_rx);
      end
   end

   // Compare each delivered item with the oldest pending estimate
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_est.size() == 0) begin
            report_mismatch("item with nothing pending", rsp_bus.level_est, '0);
         end else begin
            want = pending_est.pop_front();
            if (rsp_bus.level_est !== want.level)
               report_mismatch("level_est", rsp_bus.level_est, want.level);
            if (rsp_bus.rate_est !== want.rate)
               report_mismatch("rate_est", rsp_bus.rate_est, want.rate);
            if (rsp_bus.accel_est !== want.accel)
               report_mismatch("accel_est", rsp_bus.accel_est, want.accel);
            if (rsp_bus.jerk_est !== want.jerk)
               report_mismatch("jerk_est", rsp_bus.jerk_est, want.jerk);
            if (rsp_bus.window_full !== want.full)
               report_mismatch("window_full", 64'(rsp_bus.window_full), 64'(want.full));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      stim_row_t        row;
      bit               hit;
      int               counted;
      int               phase;
      int               win;
      int               ord;
      int               n;
      int               r;
      int               rp;
      int               tail;
      bit               live;
      logic [CMD_W-1:0] cmd;
      logic [7:0]       wdata;
      logic [7:0]       odata;

      errors = 0;
      steady_tx = 1'b0;
      steady_rx = 1'b0;
      hist_slot = 0;
      hist_fill = 0;
      cfg_window = 0;
      cfg_order = 0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.command = CMD_SAMPLE;
      req_bus.value = '0;
      req_bus.coef_order = '0;
      req_bus.coef_index = '0;
      req_bus.coef_value = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;

      // Directed table: unconfigured cases, warm-up echoes, realign, saturation
      stim_table.push_back(item_row(CMD_SAMPLE, 32'h1234_5678, 0, 0, 0, CHK_NONE));
      stim_table.push_back(csr_row(REG_FIT_ORDER, 8'd1));
      stim_table.push_back(item_row(CMD_SAMPLE, 32'h0001_0000, 0, 0, 0, CHK_NONE));
      stim_table.push_back(csr_row(REG_WINDOW_LENGTH, 8'd1));
      stim_table.push_back(item_row(CMD_SAMPLE, 32'h0002_0000, 0, 0, 0, CHK_NONE));
      stim_table.push_back(csr_row(REG_WINDOW_LENGTH, 8'd3));
      stim_table.push_back(item_row(CMD_LOAD, 0, 0, 0, 64'd0, CHK_NONE));
      stim_table.push_back(item_row(CMD_LOAD, 0, 0, 1, 64'd0, CHK_NONE));
      stim_table.push_back(item_row(CMD_LOAD, 0, 0, 2, 64'd0, CHK_NONE));
      stim_table.push_back(item_row(CMD_LOAD, 0, 1, 0, 64'h0000_0000_0100_0000, CHK_NONE));
      stim_table.push_back(item_row(CMD_LOAD, 0, 1, 1, 64'd0, CHK_NONE));
      stim_table.push_back(item_row(CMD_LOAD, 0, 1, 2, 64'hffff_ffff_ff00_0000, CHK_NONE));
      stim_table.push_back(item_row(CMD_UNUSED, 32'h5555_aaaa, 3, 31, '1, CHK_NONE));
      stim_table.push_back(item_row(CMD_SAMPLE, 32'h7fff_ffff, 0, 0, 0, CHK_WARM));
      stim_table.push_back(item_row(CMD_SAMPLE, 32'h8000_0000, 0, 0, 0, CHK_WARM));
      stim_table.push_back(item_row(CMD_REALIGN, 32'hdead_beef, 0, 0, 0, CHK_NONE));
      stim_table.push_back(item_row(CMD_SAMPLE, 32'h7fff_ffff, 0, 0, 0, CHK_WARM));
      stim_table.push_back(item_row(CMD_SAMPLE, 32'h8000_0000, 0, 0, 0, CHK_WARM));
      stim_table.push_back(item_row(CMD_SAMPLE, 32'h0000_0000, 0, 0, 0, CHK_MODEL));
      stim_table.push_back(item_row(CMD_SAMPLE, 32'h0001_8000, 0, 0, 0, CHK_MODEL));
      // extreme coefficients against extreme differences clamp both ways
      stim_table.push_back(item_row(CMD_LOAD, 0, 1, 0, 64'h7fff_ffff_ffff_ffff, CHK_NONE));
      stim_table.push_back(item_row(CMD_SAMPLE, 32'h8000_0000, 0, 0, 0, CHK_MODEL));
      stim_table.push_back(item_row(CMD_LOAD, 0, 1, 0, 64'h8000_0000_0000_0000, CHK_NONE));
      stim_table.push_back(item_row(CMD_SAMPLE, 32'h8000_0000, 0, 0, 0, CHK_MODEL));

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (stim_table[i]) begin
         row = stim_table[i];
         if (row.kind == ROW_CSR) begin
            wait_drained();
            write_reg(row.csr_idx, row.csr_data);
         end else begin
            send_item(row.cmd, row.value, row.corder, row.cidx, row.cvalue, row.check, hit);
         end
      end

      // Fill the whole coefficient table so no unwritten entry is ever read
      for (int d = 0; d < NUM_ORDERS; d++)
         for (int k = 0; k < MAX_WIN; k++)
            send_item(CMD_LOAD, $urandom, d[1:0], k[4:0], rand_coef(1'b0), CHK_MODEL, hit);

      // Random phases, each under one register setting
      counted = 0;
      phase = 0;
      while (counted < RAND_ITEMS) begin
         if (phase < NUM_PRESETS) begin
            win = preset_win[phase];
            ord = preset_ord[phase];
         end else begin
            ord = $urandom_range(0, 3);
            win = ($urandom_range(0, 9) == 0) ? MAX_WIN : $urandom_range(0, 12);
         end
         wait_drained();
         steady_tx = ($urandom_range(0, 3) == 0);
         steady_rx = ($urandom_range(0, 3) == 0);
         wdata = 8'($urandom);
         wdata[5:0] = win[5:0];
         odata = 8'($urandom);
         odata[1:0] = ord[1:0];
         if ($urandom_range(0, 1)) begin
            write_reg(REG_WINDOW_LENGTH, wdata);
            write_reg(REG_FIT_ORDER, odata);
         end else begin
            write_reg(REG_FIT_ORDER, odata);
            write_reg(REG_WINDOW_LENGTH, wdata);
         end
         if ($urandom_range(0, 3) == 0)
            write_reg(CSR_IDX_W'($urandom_range(REG_FIRST_UNUSED, REG_LAST_INDEX)),
                      CSR_DATA_W'($urandom));

         live = win != 0 && win > ord && win <= MAX_WIN;
         n = live ? 2 * win + 30 : 10;
         rp = (win > 8) ? 1 : 6;
         for (int i = 0; i < n; i++) begin
            if (i == n / 2 && (phase == 0 || $urandom_range(0, 2) == 0)) wait_drained();
            r = $urandom_range(0, 99);
            if (r < 80) cmd = CMD_SAMPLE;
            else if (r < 80 + rp) cmd = CMD_REALIGN;
            else if (r < 96) cmd = CMD_LOAD;
            else cmd = CMD_UNUSED;
            send_item(cmd, rand_sample(), 2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                      (cmd == CMD_LOAD) ? rand_coef(1'b1) : {$urandom, $urandom},
                      CHK_MODEL, hit);
            counted += hit;
         end
         phase++;
      end

      // Drain, then watch a while longer for stray items
      @(negedge clock);
      req_bus.valid = 1'b0;
      tail = 0;
      while (pending_est.size() != 0 && tail < DRAIN_LIMIT) begin
         @(posedge clock);
         tail++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_est.size() != 0)
         report_mismatch("estimates never delivered", 64'(pending_est.size()), '0);

      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
